FILE: sv/tapc_pkg.sv
// Shared types and constants for the three-axis PID controller.
// Holds field widths, register indexes, lane operation codes and the control word.
// No dependencies.
`default_nettype none

package tapc_pkg;

  // Build defaults handed to the top level parameters.
  localparam int unsigned AXES_DEFAULT        = 3;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // Fixed field widths.
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Width of the multiplier's magnitude operand; wider values go in two chunks.
  localparam int unsigned MUL_A_W = 32;

  // Register values after reset.
  localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET    = 24'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 24'd0;
  localparam logic [STEP_W-1:0] STEP_TIME_RESET = 16'd1311;
  localparam logic [STEP_W-1:0] STEP_RATE_RESET = 16'd50;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X  = 4'd0,
    REG_TARGET_Y  = 4'd1,
    REG_TARGET_Z  = 4'd2,
    REG_GAIN_P    = 4'd3,
    REG_GAIN_I    = 4'd4,
    REG_GAIN_D    = 4'd5,
    REG_STEP_TIME = 4'd6,
    REG_STEP_RATE = 4'd7
  } cfg_reg_e;

  // Products each lane forms in turn, in this order.
  typedef enum logic [2:0] {
    OP_TIME  = 3'd0,  // error times dt, feeds the integral
    OP_RATE  = 3'd1,  // error change times rate, the derivative
    OP_PROP  = 3'd2,  // Kp times error
    OP_INTEG = 3'd3,  // Ki times integral
    OP_DERIV = 3'd4   // Kd times derivative
  } op_e;

  // Control word from the sequencer to every lane.
  typedef struct packed {
    logic err_en;
    logic load_en;
    logic lo_en;
    logic hi_en;
    logic fin_en;
    logic apply_en;
    logic out_en;
    op_e  op;
  } ctrl_t;

  // Register index of the setpoint for one axis.
  function automatic cfg_reg_e target_index(input int unsigned axis);
    cfg_reg_e idx;
    unique case (axis)
      0:       idx = REG_TARGET_X;
      1:       idx = REG_TARGET_Y;
      default: idx = REG_TARGET_Z;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tapc_seq.sv
// Sequencer shared by all PID lanes: steps the lanes through their products.
// Also owns the input ready and the output valid flag.
// Depends on tapc_pkg.
`default_nettype none

module tapc_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output tapc_pkg::ctrl_t ctrl
);
  import tapc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_LO    = 7'b0000100,
    S_HI    = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_APPLY = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  op_e    op;
  logic   accept;
  logic   out_free;
  logic   last_op;

  function automatic op_e following_op(input op_e cur);
    op_e nxt;
    unique case (cur)
      OP_TIME:  nxt = OP_RATE;
      OP_RATE:  nxt = OP_PROP;
      OP_PROP:  nxt = OP_INTEG;
      OP_INTEG: nxt = OP_DERIV;
      default:  nxt = OP_TIME;
    endcase
    return nxt;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign last_op  = (op == OP_DERIV);

  // Next state: five phases per product, then a final saturating step.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_LOAD;
      S_LOAD:  state_next = S_LO;
      S_LO:    state_next = S_HI;
      S_HI:    state_next = S_FIN;
      S_FIN:   state_next = S_APPLY;
      S_APPLY: state_next = last_op ? S_FINAL : S_LOAD;
      S_FINAL: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Product counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_TIME;
    end else if (accept) begin
      op <= OP_TIME;
    end else if (state == S_APPLY) begin
      op <= following_op(op);
    end
  end

  // The output word stays valid until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Control word to the lanes.
  always_comb begin
    ctrl.err_en   = accept;
    ctrl.load_en  = (state == S_LOAD);
    ctrl.lo_en    = (state == S_LO);
    ctrl.hi_en    = (state == S_HI);
    ctrl.fin_en   = (state == S_FIN);
    ctrl.apply_en = (state == S_APPLY);
    ctrl.out_en   = (state == S_FINAL) && out_free;
    ctrl.op       = op;
  end

endmodule

`default_nettype wire

FILE: sv/tapc_lane.sv
// One PID lane: error, integral, derivative and drive for a single axis.
// Uses one 32x24 multiplier for all of its products in turn, sequenced by tapc_seq.
// Depends on tapc_pkg.
`default_nettype none

module tapc_lane #(
  parameter int unsigned VALUE_WIDTH = tapc_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tapc_pkg::ctrl_t                      ctrl,
  input  logic signed [tapc_pkg::POS_W-1:0]    target,
  input  logic signed [tapc_pkg::POS_W-1:0]    position,
  input  logic [tapc_pkg::GAIN_W-1:0]          gain_p,
  input  logic [tapc_pkg::GAIN_W-1:0]          gain_i,
  input  logic [tapc_pkg::GAIN_W-1:0]          gain_d,
  input  logic [tapc_pkg::STEP_W-1:0]          step_time,
  input  logic [tapc_pkg::STEP_W-1:0]          step_rate,
  output logic signed [tapc_pkg::DRIVE_W-1:0]  drive,
  output logic                                 clip
);
  import tapc_pkg::*;

  localparam int unsigned MAG_W  = VALUE_WIDTH + 1;
  localparam int unsigned ACC_W  = MAG_W + GAIN_W;
  localparam int unsigned TERM_W = ACC_W + 1;
  localparam int unsigned SUM_W  = ACC_W + 3;
  localparam int unsigned OUT_W  = (VALUE_WIDTH < DRIVE_W) ? VALUE_WIDTH : DRIVE_W;
  localparam int unsigned PAD_W  = 2 * MUL_A_W;
  localparam int unsigned PROD_W = MUL_A_W + GAIN_W;

  // Saturate to VALUE_WIDTH; the top bit of the result is the clip flag.
  function automatic logic [VALUE_WIDTH:0] sat_value(input logic signed [SUM_W-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[SUM_W-1:VALUE_WIDTH-1];
    all_zeros = ~|x[SUM_W-1:VALUE_WIDTH-1];
    if (all_ones || all_zeros) begin
      return {1'b0, x[VALUE_WIDTH-1:0]};
    end else if (x[SUM_W-1]) begin
      return {1'b1, 1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Saturate to the drive width; the top bit of the result is the clip flag.
  function automatic logic [OUT_W:0] sat_drive(input logic signed [SUM_W-1:0] x);
    logic all_ones;
    logic all_zeros;
    all_ones  = &x[SUM_W-1:OUT_W-1];
    all_zeros = ~|x[SUM_W-1:OUT_W-1];
    if (all_ones || all_zeros) begin
      return {1'b0, x[OUT_W-1:0]};
    end else if (x[SUM_W-1]) begin
      return {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  // Loop state, cleared at reset.
  logic signed [VALUE_WIDTH-1:0] error_sum;
  logic signed [VALUE_WIDTH-1:0] last_error;

  // Working registers for the current sample.
  logic signed [VALUE_WIDTH-1:0] err;
  logic signed [VALUE_WIDTH-1:0] deriv;
  logic [MAG_W-1:0]              mag;
  logic                          neg;
  logic [GAIN_W-1:0]             gain_reg;
  logic [ACC_W-1:0]              acc;
  logic signed [TERM_W-1:0]      term;
  logic signed [SUM_W-1:0]       sum;
  logic                          clip_acc;

  logic signed [SUM_W-1:0]       err_wide;
  logic [VALUE_WIDTH:0]          err_sat;
  logic signed [MAG_W-1:0]       opnd;
  logic [MAG_W-1:0]              opnd_bits;
  logic [MAG_W-1:0]              mag_next;
  logic [GAIN_W-1:0]             gain_next;
  logic [PAD_W-1:0]              mag_pad;
  logic [MUL_A_W-1:0]            mul_a;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W+MUL_A_W-1:0]     prod_hi;
  logic [ACC_W-1:0]              shifted;
  logic signed [TERM_W-1:0]      term_mag;
  logic signed [SUM_W-1:0]       apply_in;
  logic [VALUE_WIDTH:0]          apply_sat;
  logic [OUT_W:0]                drive_sat;
  logic signed [OUT_W-1:0]       drive_val;

  // Error against the setpoint, saturated.
  assign err_wide = SUM_W'(target) - SUM_W'(position);
  assign err_sat  = sat_value(err_wide);

  // Operand and gain for the next product.
  always_comb begin
    unique case (ctrl.op)
      OP_TIME: begin
        opnd      = MAG_W'(err);
        gain_next = GAIN_W'(step_time);
      end
      OP_RATE: begin
        opnd      = MAG_W'(err) - MAG_W'(last_error);
        gain_next = GAIN_W'(step_rate);
      end
      OP_PROP: begin
        opnd      = MAG_W'(err);
        gain_next = gain_p;
      end
      OP_INTEG: begin
        opnd      = MAG_W'(error_sum);
        gain_next = gain_i;
      end
      OP_DERIV: begin
        opnd      = MAG_W'(deriv);
        gain_next = gain_d;
      end
      default: begin
        opnd      = MAG_W'(err);
        gain_next = gain_p;
      end
    endcase
  end

  assign opnd_bits = opnd;
  assign mag_next  = opnd[MAG_W-1] ? (~opnd_bits + 1'b1) : opnd_bits;

  // Magnitude product, low chunk then high chunk.
  assign mag_pad = PAD_W'(mag);
  assign mul_a   = ctrl.hi_en ? mag_pad[PAD_W-1:MUL_A_W] : mag_pad[MUL_A_W-1:0];
  assign prod    = PROD_W'(mul_a) * PROD_W'(gain_reg);
  assign prod_hi = {prod, {MUL_A_W{1'b0}}};

  // Scale the magnitude back to Q16.16, truncating; the rate product is not shifted.
  assign shifted  = (ctrl.op == OP_RATE) ? acc : (acc >> FRAC_W);
  assign term_mag = TERM_W'(shifted);

  // The integral adds its term to the running sum; the derivative saturates alone.
  assign apply_in  = (ctrl.op == OP_TIME) ? (SUM_W'(error_sum) + SUM_W'(term))
                                          : SUM_W'(term);
  assign apply_sat = sat_value(apply_in);

  assign drive_sat = sat_drive(sum);
  assign drive_val = drive_sat[OUT_W-1:0];

  // Integral and last error.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctrl.apply_en) begin
      if (ctrl.op == OP_TIME) begin
        error_sum <= apply_sat[VALUE_WIDTH-1:0];
      end
      if (ctrl.op == OP_RATE) begin
        last_error <= err;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctrl.err_en) begin
      err      <= err_sat[VALUE_WIDTH-1:0];
      clip_acc <= err_sat[VALUE_WIDTH];
    end
    if (ctrl.load_en) begin
      mag      <= mag_next;
      neg      <= opnd[MAG_W-1];
      gain_reg <= gain_next;
    end
    if (ctrl.lo_en) begin
      acc <= ACC_W'(prod);
    end
    if (ctrl.hi_en) begin
      acc <= acc + ACC_W'(prod_hi);
    end
    if (ctrl.fin_en) begin
      term <= neg ? -term_mag : term_mag;
    end
    if (ctrl.apply_en) begin
      unique case (ctrl.op)
        OP_TIME: begin
          clip_acc <= clip_acc | apply_sat[VALUE_WIDTH];
        end
        OP_RATE: begin
          deriv    <= apply_sat[VALUE_WIDTH-1:0];
          clip_acc <= clip_acc | apply_sat[VALUE_WIDTH];
        end
        OP_PROP: begin
          sum <= SUM_W'(term);
        end
        default: begin
          sum <= sum + SUM_W'(term);
        end
      endcase
    end
    if (ctrl.out_en) begin
      drive <= DRIVE_W'(drive_val);
      clip  <= clip_acc | drive_sat[OUT_W];
    end
  end

endmodule

`default_nettype wire

FILE: sv/three_axis_pid_controller_core.sv
// Top level of the three-axis PID controller: configuration registers,
// one tapc_lane per axis, the shared tapc_seq and the merge of the lane flags.
// Depends on tapc_pkg, tapc_seq and tapc_lane.
//
//   Channel   Signals                                   Direction  Handshake
//   config    cfg_we, cfg_index, cfg_data               in         write enable
//   sample    in_valid, in_ready, position_x/y/z        in         valid/ready
//   command   out_valid, out_ready, drive_x/y/z, clipped out       valid/ready
//
// A sample is accepted only in the idle state, so a new one is not taken until
// the result word of the last one has been loaded into the output. Each lane runs
// five products through a single 32x24 multiplier, one after another.
// Reset clears the integrals, the last errors and the control state, and loads
// the register defaults. A new sample is taken while an older word waits on
// out_ready; the finished word of that sample then waits until the slot is free.
`default_nettype none

module three_axis_pid_controller_core #(
  parameter int unsigned AXES        = tapc_pkg::AXES_DEFAULT,
  parameter int unsigned VALUE_WIDTH = tapc_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tapc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tapc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tapc_pkg::POS_W-1:0]      position_x,
  input  logic signed [tapc_pkg::POS_W-1:0]      position_y,
  input  logic signed [tapc_pkg::POS_W-1:0]      position_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tapc_pkg::DRIVE_W-1:0]    drive_x,
  output logic signed [tapc_pkg::DRIVE_W-1:0]    drive_y,
  output logic signed [tapc_pkg::DRIVE_W-1:0]    drive_z,
  output logic                                   clipped
);
  import tapc_pkg::*;

  logic signed [POS_W-1:0]   target [AXES];
  logic [GAIN_W-1:0]         gain_p;
  logic [GAIN_W-1:0]         gain_i;
  logic [GAIN_W-1:0]         gain_d;
  logic [STEP_W-1:0]         step_time;
  logic [STEP_W-1:0]         step_rate;

  logic signed [POS_W-1:0]   pos_in     [3];
  logic signed [DRIVE_W-1:0] lane_drive [3];
  logic [2:0]                lane_clip;
  ctrl_t                     ctrl;

  // Setpoints, one per axis in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        target[a] <= '0;
      end
    end else if (cfg_we) begin
      for (int a = 0; a < AXES; a++) begin
        if (cfg_index == target_index(a)) begin
          target[a] <= cfg_data;
        end
      end
    end
  end

  // Gains and timing registers; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= GAIN_P_RESET;
      gain_i    <= GAIN_I_RESET;
      gain_d    <= GAIN_D_RESET;
      step_time <= STEP_TIME_RESET;
      step_rate <= STEP_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:    gain_p    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d    <= cfg_data[GAIN_W-1:0];
        REG_STEP_TIME: step_time <= cfg_data[STEP_W-1:0];
        REG_STEP_RATE: step_rate <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tapc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  assign pos_in[0] = position_x;
  assign pos_in[1] = position_y;
  assign pos_in[2] = position_z;

  // One lane per axis in use; missing axes drive zero.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    if (a < AXES) begin : g_lane
      tapc_lane #(
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .target    (target[a]),
        .position  (pos_in[a]),
        .gain_p    (gain_p),
        .gain_i    (gain_i),
        .gain_d    (gain_d),
        .step_time (step_time),
        .step_rate (step_rate),
        .drive     (lane_drive[a]),
        .clip      (lane_clip[a])
      );
    end else begin : g_idle
      assign lane_drive[a] = '0;
      assign lane_clip[a]  = 1'b0;
    end
  end

  // Merge the lanes into one result word.
  assign drive_x = lane_drive[0];
  assign drive_y = lane_drive[1];
  assign drive_z = lane_drive[2];
  assign clipped = |lane_clip;

endmodule

`default_nettype wire
